>>> sv/rcsf_pkg.sv
// ----------------------------------------------------------------------------
// RGB CRT subpixel filter package
// Shared constants, codes, types and the small arithmetic helpers used by the
// neighbour window and the subpixel emitter.
// ----------------------------------------------------------------------------
package rcsf_pkg;

   // Configuration port geometry
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_HORIZONTAL_MODE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCANLINE_ENABLE = 8'd1;

   // Horizontal expansion modes; the unused code behaves as stripes
   localparam logic [1:0] MODE_MONO    = 2'd0;
   localparam logic [1:0] MODE_COLUMN  = 2'd1;
   localparam logic [1:0] MODE_STRIPES = 2'd2;

   // Register reset values
   localparam logic [1:0] HORIZONTAL_MODE_RESET = MODE_MONO;
   localparam logic       SCANLINE_ENABLE_RESET = 1'b1;

   // Scaling and offsets
   localparam int         SCALE_MULT  = 180;
   localparam logic [7:0] OFFSET_FULL = 8'd32;
   localparam logic [7:0] OFFSET_HALF = 8'd16;

   // Channel positions
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Blurred channel sum with its 5/8 and 3/8 reductions
   typedef struct packed {
      logic [8:0] sum;
      logic [7:0] five;
      logic [6:0] three;
   } chan_sum_type;

   // One pixel waiting to be expanded into subpixels
   typedef struct packed {
      logic                   valid;
      logic                   bright;
      chan_sum_type [2:0]     ch;
   } pix_job_type;

   typedef struct packed {
      logic [1:0] horizontal_mode;
      logic       scanline_enable;
   } cfg_type;

   typedef struct packed {
      logic [7:0] normal_red;
      logic [7:0] normal_green;
      logic [7:0] normal_blue;
      logic [7:0] scan_red;
      logic [7:0] scan_green;
      logic [7:0] scan_blue;
      logic [1:0] sub_index;
      logic       line_done;
      logic       run_last;
   } rsp_payload_type;

   // left/8 + centre + right/8, with its 5/8 and 3/8 scaled forms
   function automatic chan_sum_type blur_prep(input logic [7:0] left,
                                              input logic [7:0] centre,
                                              input logic [7:0] right);
      chan_sum_type r;
      logic [10:0]  m5;
      logic [9:0]   m3;
      r.sum   = {4'b0, left[7:3]} + {1'b0, centre} + {4'b0, right[7:3]};
      m5      = {2'b0, r.sum} + {r.sum, 2'b0};
      m3      = {1'b0, r.sum} + {r.sum, 1'b0};
      r.five  = m5[10:3];
      r.three = m3[9:3];
      return r;
   endfunction

   // (v * 180) >> 8; the product stays below 2^16 for sums up to 317
   function automatic logic [7:0] scale_by(input logic [8:0] v);
      logic [16:0] p;
      p = 17'(v) * 17'(SCALE_MULT);
      return p[15:8];
   endfunction

endpackage

>>> sv/rcsf_if.sv
// ----------------------------------------------------------------------------
// RGB CRT subpixel filter channels
// Valid/ready interfaces for the pixel input, the subpixel result and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface rcsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_red;
   logic [7:0] pixel_green;
   logic [7:0] pixel_blue;
   logic       keep_bright;
   logic       end_of_line;

   modport source (output valid, pixel_red, pixel_green, pixel_blue, keep_bright,
                   end_of_line, input ready);
   modport sink   (input valid, pixel_red, pixel_green, pixel_blue, keep_bright,
                   end_of_line, output ready);
endinterface

interface rcsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] normal_red;
   logic [7:0] normal_green;
   logic [7:0] normal_blue;
   logic [7:0] scan_red;
   logic [7:0] scan_green;
   logic [7:0] scan_blue;
   logic [1:0] sub_index;
   logic       line_done;
   logic       run_last;

   modport source (output valid, normal_red, normal_green, normal_blue, scan_red,
                   scan_green, scan_blue, sub_index, line_done, run_last,
                   input ready);
   modport sink   (input valid, normal_red, normal_green, normal_blue, scan_red,
                   scan_green, scan_blue, sub_index, line_done, run_last,
                   output ready);
endinterface

interface rcsf_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

>>> sv/rcsf_window.sv
// ----------------------------------------------------------------------------
// RGB CRT subpixel filter neighbour window
// Holds the left neighbour and the pending centre pixel of the current line
// and forms the blurred channel sums of the pixels that an input releases.
// ----------------------------------------------------------------------------
module rcsf_window
   import rcsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  rgb_type     cur_rgb,
   input  logic        cur_bright,
   input  logic        cur_eol,
   output pix_job_type job_a,
   output pix_job_type job_b
);

   rgb_type left_ff,   left_in;
   rgb_type centre_ff, centre_in;
   logic    centre_bright_ff, centre_bright_in;
   logic    centre_valid_ff,  centre_valid_in;

   rgb_type next_left;
   rgb_type zero_rgb;

   assign zero_rgb  = '0;
   // Once the held pixel is released it becomes the left neighbour.
   assign next_left = centre_valid_ff ? centre_ff : left_ff;

   always_comb begin
      job_a.valid  = centre_valid_ff;
      job_a.bright = centre_bright_ff;
      job_a.ch[CH_RED]   = blur_prep(left_ff.red,   centre_ff.red,   cur_rgb.red);
      job_a.ch[CH_GREEN] = blur_prep(left_ff.green, centre_ff.green, cur_rgb.green);
      job_a.ch[CH_BLUE]  = blur_prep(left_ff.blue,  centre_ff.blue,  cur_rgb.blue);

      // End of line: the current pixel goes out with a black right neighbour.
      job_b.valid  = cur_eol;
      job_b.bright = cur_bright;
      job_b.ch[CH_RED]   = blur_prep(next_left.red,   cur_rgb.red,   zero_rgb.red);
      job_b.ch[CH_GREEN] = blur_prep(next_left.green, cur_rgb.green, zero_rgb.green);
      job_b.ch[CH_BLUE]  = blur_prep(next_left.blue,  cur_rgb.blue,  zero_rgb.blue);
   end

   always_comb begin
      left_in          = left_ff;
      centre_in        = centre_ff;
      centre_bright_in = centre_bright_ff;
      centre_valid_in  = centre_valid_ff;
      if (accept) begin
         if (cur_eol) begin
            left_in          = '0;
            centre_in        = '0;
            centre_bright_in = 1'b0;
            centre_valid_in  = 1'b0;
         end else begin
            left_in          = next_left;
            centre_in        = cur_rgb;
            centre_bright_in = cur_bright;
            centre_valid_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff          <= '0;
         centre_ff        <= '0;
         centre_bright_ff <= 1'b0;
         centre_valid_ff  <= 1'b0;
      end else begin
         left_ff          <= left_in;
         centre_ff        <= centre_in;
         centre_bright_ff <= centre_bright_in;
         centre_valid_ff  <= centre_valid_in;
      end
   end

endmodule

>>> sv/rcsf_emitter.sv
// ----------------------------------------------------------------------------
// RGB CRT subpixel filter emitter
// Holds up to two released pixels, steps through their subpixels, computes
// the normal and scanline colours and presents them in the result register.
// ----------------------------------------------------------------------------
module rcsf_emitter
   import rcsf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            load,
   input  pix_job_type     job_a,
   input  pix_job_type     job_b,
   output logic            take_ready,
   rcsf_rsp_if.source      rsp_if
);

   pix_job_type     a_ff,   a_in;
   pix_job_type     b_ff,   b_in;
   logic [1:0]      sub_ff, sub_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   pix_job_type     cur;
   logic            active;
   logic [1:0]      sub_last_idx;
   logic            sub_last;
   logic            job_last;
   logic            out_free;
   logic            step;
   logic            stripes;
   logic            wide;
   logic            bright;
   logic [7:0]      offset;
   logic [7:0]      nv [3];
   logic [7:0]      sv [3];

   assign active   = a_ff.valid || b_ff.valid;
   assign cur      = a_ff.valid ? a_ff : b_ff;
   assign stripes  = (cfg.horizontal_mode != MODE_MONO) &&
                     (cfg.horizontal_mode != MODE_COLUMN);

   always_comb begin
      case (cfg.horizontal_mode)
         MODE_MONO:   sub_last_idx = 2'd0;
         MODE_COLUMN: sub_last_idx = 2'd1;
         default:     sub_last_idx = 2'd2;
      endcase
   end

   assign sub_last   = (sub_ff == sub_last_idx);
   assign job_last   = sub_last && !(a_ff.valid && b_ff.valid);
   assign out_free   = !out_valid_ff || rsp_if.ready;
   assign step       = active && out_free;
   // A new pixel may be taken in the same cycle as the last subpixel moves out.
   assign take_ready = !active || (out_free && job_last);

   // Full-strength subpixel: stripes or the first column; otherwise the dim one.
   assign wide   = stripes || (sub_ff == 2'd0);
   assign bright = cur.bright || !cfg.scanline_enable;
   assign offset = wide ? OFFSET_FULL : OFFSET_HALF;

   always_comb begin
      logic [8:0] nop;
      logic [8:0] dop;
      logic [7:0] dim;
      for (int c = 0; c < 3; c++) begin
         nop   = wide    ? cur.ch[c].sum : {1'b0, cur.ch[c].five};
         dop   = stripes ? {1'b0, cur.ch[c].five} : {2'b0, cur.ch[c].three};
         nv[c] = offset + scale_by(nop);
         dim   = offset + scale_by(dop);
         sv[c] = bright ? nv[c] : dim;
         if (stripes && (sub_ff != 2'(c))) begin
            nv[c] = '0;
            sv[c] = '0;
         end
      end
   end

   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      sub_in       = sub_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step) begin
         out_valid_in        = 1'b1;
         out_in.normal_red   = nv[CH_RED];
         out_in.normal_green = nv[CH_GREEN];
         out_in.normal_blue  = nv[CH_BLUE];
         out_in.scan_red     = sv[CH_RED];
         out_in.scan_green   = sv[CH_GREEN];
         out_in.scan_blue    = sv[CH_BLUE];
         out_in.sub_index    = sub_ff;
         out_in.line_done    = sub_last && !a_ff.valid;
         out_in.run_last     = job_last;
         if (sub_last) begin
            sub_in = 2'd0;
            if (a_ff.valid) begin
               a_in.valid = 1'b0;
            end else begin
               b_in.valid = 1'b0;
            end
         end else begin
            sub_in = sub_ff + 2'd1;
         end
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         a_in   = job_a;
         b_in   = job_b;
         sub_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid   <= 1'b0;
         b_ff.valid   <= 1'b0;
         sub_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         a_ff         <= a_in;
         b_ff         <= b_in;
         sub_ff       <= sub_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.normal_red   = out_ff.normal_red;
   assign rsp_if.normal_green = out_ff.normal_green;
   assign rsp_if.normal_blue  = out_ff.normal_blue;
   assign rsp_if.scan_red     = out_ff.scan_red;
   assign rsp_if.scan_green   = out_ff.scan_green;
   assign rsp_if.scan_blue    = out_ff.scan_blue;
   assign rsp_if.sub_index    = out_ff.sub_index;
   assign rsp_if.line_done    = out_ff.line_done;
   assign rsp_if.run_last     = out_ff.run_last;

endmodule

>>> sv/rgb_crt_subpixel_filter.sv
// An input transfer loads the pixels it releases into the emitter; their
// subpixels then move one by one to the single result register. Throughput:
// one result per cycle while the result channel is ready. An input causes
// zero to six results, three per pixel in stripe mode; no new input is taken
// before its last result moves out. Reset is synchronous and clears the line state.
// ----------------------------------------------------------------------------
// RGB CRT subpixel filter
// Horizontal CRT-style blur and subpixel expansion with scanline dimming,
// configured through a small register write channel.
// ----------------------------------------------------------------------------
module rgb_crt_subpixel_filter
   import rcsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rcsf_req_if.sink    req_if,
   rcsf_rsp_if.source  rsp_if,
   rcsf_csr_if.sink    csr_if
);

   cfg_type     cfg_ff, cfg_in;
   pix_job_type job_a;
   pix_job_type job_b;
   logic        take_ready;
   logic        accept;
   rgb_type     cur_rgb;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            REG_HORIZONTAL_MODE: cfg_in.horizontal_mode = csr_if.wdata[1:0];
            REG_SCANLINE_ENABLE: cfg_in.scanline_enable = csr_if.wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.horizontal_mode <= HORIZONTAL_MODE_RESET;
         cfg_ff.scanline_enable <= SCANLINE_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_if.ready  = take_ready;
   assign accept        = req_if.valid && take_ready;
   assign cur_rgb.red   = req_if.pixel_red;
   assign cur_rgb.green = req_if.pixel_green;
   assign cur_rgb.blue  = req_if.pixel_blue;

   rcsf_window u_window (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cur_rgb    (cur_rgb),
      .cur_bright (req_if.keep_bright),
      .cur_eol    (req_if.end_of_line),
      .job_a      (job_a),
      .job_b      (job_b)
   );

   rcsf_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .load       (accept),
      .job_a      (job_a),
      .job_b      (job_b),
      .take_ready (take_ready),
      .rsp_if     (rsp_if)
   );

endmodule

>>> sv/rcsf_checker.sv
// ----------------------------------------------------------------------------
// RGB CRT subpixel filter checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rcsf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_normal_red,
   input logic [7:0] rsp_scan_red,
   input logic [1:0] rsp_sub_index,
   input logic       rsp_line_done,
   input logic       rsp_run_last
);

   // A stalled result stays offered, with its red values, subpixel position and run_last unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_normal_red) &&
         $stable(rsp_scan_red) && $stable(rsp_sub_index) && $stable(rsp_run_last))
      else $error("result changed while stalled");

   // The end of an output line is always the last result of its input.
   a_line_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_done |-> rsp_run_last)
      else $error("line_done without run_last");

   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sub_index != 2'd3)
      else $error("subpixel position out of range");

   // Nothing is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind rgb_crt_subpixel_filter rcsf_checker u_rcsf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_normal_red (rsp_if.normal_red),
   .rsp_scan_red   (rsp_if.scan_red),
   .rsp_sub_index  (rsp_if.sub_index),
   .rsp_line_done  (rsp_if.line_done),
   .rsp_run_last   (rsp_if.run_last)
);
